// ===== rtl/psl_pkg.sv =====
package psl_pkg;

    localparam logic [1:0] CMD_POISSON = 2'd0;
    localparam logic [1:0] CMD_UNIFORM = 2'd1;
    localparam logic [1:0] CMD_RESEED  = 2'd2;

    localparam int CMD_W   = 2;
    localparam int SEED_W  = 32;
    localparam int THR_W   = 33;
    localparam int COUNT_W = 8;
    localparam int UNI_W   = 31;
    localparam int OUT_W   = 48;

    localparam logic [16:0] LCG_MULT  = 17'd69069;
    localparam logic [31:0] DRAW_MASK = 32'h7FFF_FF00;
    localparam logic [32:0] THR_ONE   = 33'h1_0000_0000;

    typedef struct packed {
        logic latch_in;
        logic start;
        logic reseed;
        logic step_gen;
        logic mul;
        logic acc;
        logic inc_cnt;
        logic set_sat;
        logic take_uni;
        logic out_load;
    } t_dp_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             thr_ge_one;
        logic             masked_zero;
        logic             prod_le_thr;
        logic             cnt_at_max;
    } t_dp_sts;

endpackage

// ===== rtl/psl_ctrl.sv =====
module psl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  psl_pkg::t_dp_sts i_sts,
    output psl_pkg::t_dp_ctl o_ctl
);
    import psl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_GEN  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_dp_ctl    w_ctl;

    always_comb begin
        w_ctl   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.latch_in = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                w_ctl.start = 1'b1;
                case (i_sts.cmd)
                    CMD_POISSON: n_state = i_sts.thr_ge_one ? S_OUT : S_GEN;
                    CMD_UNIFORM: n_state = S_GEN;
                    CMD_RESEED: begin
                        w_ctl.reseed = 1'b1;
                        n_state      = S_OUT;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_GEN: begin
                w_ctl.step_gen = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                if (i_sts.masked_zero) begin
                    n_state = S_GEN;
                end else if (i_sts.cmd == CMD_UNIFORM) begin
                    w_ctl.take_uni = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    w_ctl.mul = 1'b1;
                    n_state   = S_ACC;
                end
            end
            S_ACC: begin
                w_ctl.acc = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (i_sts.prod_le_thr) begin
                    n_state = S_OUT;
                end else if (i_sts.cnt_at_max) begin
                    w_ctl.set_sat = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    w_ctl.inc_cnt = 1'b1;
                    n_state       = S_GEN;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ctl       = w_ctl;

    // a product step always follows an accepted nonzero draw
    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ($past(r_state) == S_CHK && !$past(i_sts.masked_zero)))
        else $error("accumulate without a preceding multiply");

    // a loaded result is never overwritten while still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result beat overwritten");

    // uniform draws never enter the product loop
    a_uni_no_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (i_sts.cmd == CMD_POISSON))
        else $error("product step on a non-poisson command");

endmodule

// ===== rtl/psl_dp.sv =====
module psl_dp #(
    parameter int MAX_COUNT         = 255,
    parameter int PRODUCT_FRAC_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [psl_pkg::THR_W-1:0]  i_cfg_data,
    input  logic [psl_pkg::CMD_W-1:0]  i_cmd,
    input  logic [psl_pkg::SEED_W-1:0] i_seed,
    input  psl_pkg::t_dp_ctl           i_ctl,
    output psl_pkg::t_dp_sts           o_sts,
    output logic [psl_pkg::COUNT_W-1:0] o_count,
    output logic [psl_pkg::UNI_W-1:0]  o_uniform,
    output logic                       o_saturated,
    output logic                       o_seed_error
);
    import psl_pkg::*;

    localparam int PW = PRODUCT_FRAC_BITS + 1;
    localparam int HW = PW - 24;
    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int MW = 23;

    logic [THR_W-1:0]   r_thr;
    logic [SEED_W-1:0]  r_gen;
    logic [CMD_W-1:0]   r_cmd;
    logic [SEED_W-1:0]  r_seed;
    logic [PW-1:0]      r_prod;
    logic [HW+MW-1:0]   r_phi;
    logic [24+MW-1:0]   r_plo;
    logic [CW-1:0]      r_cnt;
    logic [UNI_W-1:0]   r_uni;
    logic               r_sat;
    logic               r_serr;
    logic [COUNT_W-1:0] r_o_count;
    logic [UNI_W-1:0]   r_o_uni;
    logic               r_o_sat;
    logic               r_o_serr;

    logic [48:0]   w_gen_mul;
    logic [MW-1:0] w_m;
    logic [PW-1:0] w_thr;
    logic [PW-1:0] n_prod;
    logic          w_seed_bad;

    assign w_gen_mul  = 49'(r_gen) * 49'(LCG_MULT);
    assign w_m        = r_gen[30:8];
    assign w_seed_bad = (r_seed[30:0] == 31'd0);
    assign n_prod     = PW'({r_phi, 1'b0}) + PW'(r_plo >> MW);

    generate
        if (PRODUCT_FRAC_BITS >= 32) begin : g_thr_up
            assign w_thr = PW'(r_thr[31:0]) << (PRODUCT_FRAC_BITS - 32);
        end else begin : g_thr_dn
            assign w_thr = PW'(r_thr[31:0] >> (32 - PRODUCT_FRAC_BITS));
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_ONE;
            r_gen  <= 32'd1;
            r_cnt  <= '0;
            r_prod <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (i_ctl.reseed && !w_seed_bad) begin
                r_gen <= r_seed;
            end else if (i_ctl.step_gen) begin
                r_gen <= w_gen_mul[31:0];
            end
            if (i_ctl.start) begin
                r_cnt  <= '0;
                r_prod <= PW'(1) << PRODUCT_FRAC_BITS;
            end else begin
                if (i_ctl.inc_cnt) begin
                    r_cnt <= CW'(r_cnt + 1'b1);
                end
                if (i_ctl.acc) begin
                    r_prod <= n_prod;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_cmd  <= i_cmd;
            r_seed <= i_seed;
        end
        if (i_ctl.mul) begin
            r_phi <= (HW+MW)'(r_prod[PW-1:24]) * (HW+MW)'(w_m);
            r_plo <= (24+MW)'(r_prod[23:0]) * (24+MW)'(w_m);
        end
        if (i_ctl.start) begin
            r_uni  <= '0;
            r_sat  <= 1'b0;
            r_serr <= i_ctl.reseed && w_seed_bad;
        end else begin
            if (i_ctl.take_uni) begin
                r_uni <= r_gen[30:0] & DRAW_MASK[30:0];
            end
            if (i_ctl.set_sat) begin
                r_sat <= 1'b1;
            end
        end
        if (i_ctl.out_load) begin
            r_o_count <= COUNT_W'(r_cnt);
            r_o_uni   <= r_uni;
            r_o_sat   <= r_sat;
            r_o_serr  <= r_serr;
        end
    end

    assign o_sts.cmd         = r_cmd;
    assign o_sts.thr_ge_one  = r_thr[32];
    assign o_sts.masked_zero = (w_m == '0);
    assign o_sts.prod_le_thr = (r_prod <= w_thr);
    assign o_sts.cnt_at_max  = (r_cnt == CW'(MAX_COUNT));

    assign o_count      = r_o_count;
    assign o_uniform    = r_o_uni;
    assign o_saturated  = r_o_sat;
    assign o_seed_error = r_o_serr;

    // odd multiplier and rejected seeds keep the low 31 bits alive
    a_gen_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_gen[30:0] != 31'd0))
        else $error("generator collapsed to a dead state");

    // the product only shrinks from one
    a_prod_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.acc |=> (r_prod <= (PW'(1) << PRODUCT_FRAC_BITS)))
        else $error("product above one");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.inc_cnt |=> (r_cnt == CW'($past(r_cnt) + 1'b1)
            && r_cnt <= CW'(MAX_COUNT)))
        else $error("draw counter stepped wrongly");

endmodule

// ===== rtl/poisson_sampler_lcg_top.sv =====
// Poisson sampler on a 32-bit multiplicative generator (state * 69069). Each input beat carries
// a command in tuser (0 Poisson draw, 1 raw uniform draw, 2 reseed, 3 no-op) and the seed in
// tdata; each command returns exactly one result beat. The threshold register holds exp(-mean)
// in unsigned Q1.32; a value of 1.0 or above makes a Poisson draw return zero without stepping
// the generator. Reseed with a value whose low 31 bits are zero is refused and flags seed_error.
// One item is taken at a time. A reseed, a no-op or a trivial draw goes from dispatch straight to
// the result; a uniform draw first steps the generator and checks the draw. A Poisson draw runs one
// factor per drawn value, as each factor runs a generator multiply, a split 2-part product multiply,
// an accumulate and a threshold compare in turn; every rejected zero draw repeats the generator step
// and the check. A new beat is accepted while the previous result still waits in the output register.
module poisson_sampler_lcg_top #(
    parameter int MAX_COUNT         = 255,
    parameter int PRODUCT_FRAC_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [psl_pkg::SEED_W-1:0] i_s_tdata,  // seed_value
    input  logic [psl_pkg::CMD_W-1:0] i_s_tuser,  // cmd
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [psl_pkg::OUT_W-1:0] o_m_tdata,  // count, uniform, saturated, seed_error
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [psl_pkg::THR_W-1:0] i_cfg_data
);
    import psl_pkg::*;

    t_dp_ctl            w_ctl;
    t_dp_sts            w_sts;
    logic [COUNT_W-1:0] w_count;
    logic [UNI_W-1:0]   w_uniform;
    logic               w_sat;
    logic               w_serr;

    assign o_cfg_ready = 1'b1;

    psl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    psl_dp #(
        .MAX_COUNT         (MAX_COUNT),
        .PRODUCT_FRAC_BITS (PRODUCT_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_s_tuser),
        .i_seed       (i_s_tdata),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .o_count      (w_count),
        .o_uniform    (w_uniform),
        .o_saturated  (w_sat),
        .o_seed_error (w_serr)
    );

    assign o_m_tdata = {7'd0, w_serr, w_sat, w_uniform, w_count};

endmodule
